// ----- sv/rrts_pkg.sv -----
// rrts_pkg: shared types and constants of the round-robin task scheduler
// event codes, slot states, status codes and the result record
// no dependencies
package rrts_pkg;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned TPID_W      = 16;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PID_OUT_W   = 16;
  localparam int unsigned SLOT_OUT_W  = 4;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE  = 3'd0,
    FN_TICK    = 3'd1,
    FN_EXIT    = 3'd2,
    FN_BLOCK   = 3'd3,
    FN_UNBLOCK = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    SL_FREE    = 2'd0,
    SL_READY   = 2'd1,
    SL_RUN     = 2'd2,
    SL_BLOCKED = 2'd3
  } slot_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_SLOT  = 2'd1,
    STS_NO_MATCH = 2'd2,
    STS_IDLE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] ready_count;
    logic [PID_OUT_W-1:0]   running_pid;
    logic [SLOT_OUT_W-1:0]  running_slot;
    logic                   running_valid;
    logic                   switched;
    logic [PID_OUT_W-1:0]   created_pid;
    status_e                status;
  } result_t;

endpackage

// ----- sv/round_robin_task_scheduler.sv -----
// round_robin_task_scheduler: top level with input and result registers
// depends on rrts_pkg, rrts_core and rrts_ready_fifo
//
// usage: each slave-side transaction carries one scheduler event (create,
// tick, exit, block, unblock by pid) and yields exactly one master-side
// transaction with the status and the post-event running task and queue
// depth. an event is captured in the input register, decoded against the
// slot table and written to the result register, which offers its result
// on the master side. the free-slot search and the pid match are parallel
// compares over all slots, which lets one event per cycle flow through while
// the receiver takes results. when the receiver stalls, the result register
// holds, the event register fills behind it and tready
// drops; nothing is lost or repeated. reset frees every slot, empties the
// ready queue, leaves no task running and sets the next pid to one; the
// block takes events in the first cycle after reset.
module round_robin_task_scheduler #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned PID_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // func[2:0], target_pid[18:3], new_priority[26:19]
  input  logic [rrts_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status[1:0], created_pid[17:2], switched[18], running_valid[19],
  // running_slot[23:20], running_pid[39:24], ready_count[44:40]
  output logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic                          in_valid_q, in_valid_d;
  logic [rrts_pkg::FUNC_W-1:0]   func_q;
  logic [rrts_pkg::TPID_W-1:0]   tpid_q;
  logic                          out_valid_q, out_valid_d;
  rrts_pkg::result_t             res, res_q;
  logic                          in_take, fire;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= s_axis_tdata_i[rrts_pkg::FUNC_W-1:0];
      tpid_q <= s_axis_tdata_i[rrts_pkg::FUNC_W +: rrts_pkg::TPID_W];
    end
    if (fire) begin
      res_q <= res;
    end
  end

  rrts_core #(
    .SLOTS    (SLOTS),
    .PID_BITS (PID_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_en_i     (fire),
    .func_i       (func_q),
    .target_pid_i (tpid_q),
    .res_o        (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q};

endmodule

// ----- sv/rrts_ready_fifo.sv -----
// rrts_ready_fifo: circular queue of ready slot numbers
// push is applied before pop in the same event, with bypass when empty
// depends on nothing outside this file
module rrts_ready_fifo #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [$clog2(SLOTS)-1:0]     push_slot_i,
  input  logic                         pop_i,
  output logic                         avail_o,
  output logic [$clog2(SLOTS)-1:0]     head_slot_o,
  output logic [$clog2(SLOTS+1)-1:0]   count_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [SW-1:0] mem_q [SLOTS];
  logic [SW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          push_ok, pop_ok;

  function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] ptr);
    ptr_inc = (ptr == SW'(SLOTS - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign push_ok     = push_i && (count_q != CW'(SLOTS));
  assign avail_o     = (count_q != '0) || push_ok;
  assign head_slot_o = (count_q != '0) ? mem_q[head_q] : push_slot_i;
  assign pop_ok      = pop_i && avail_o;

  always_comb begin
    head_d  = pop_ok ? ptr_inc(head_q) : head_q;
    tail_d  = push_ok ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (!push_ok && pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[tail_q] <= push_slot_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("ready queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty ready queue with unequal pointers");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !push_ok) |=> (count_q == $past(count_q) - 1'b1))
    else $error("ready queue count not decremented on pop");

endmodule

// ----- sv/rrts_core.sv -----
// rrts_core: slot table, running task, pid counter and event decode
// uses rrts_pkg types and one rrts_ready_fifo instance
// all state moves in the cycle that evt_en_i is high
module rrts_core #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned PID_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         evt_en_i,
  input  logic [rrts_pkg::FUNC_W-1:0]  func_i,
  input  logic [rrts_pkg::TPID_W-1:0]  target_pid_i,
  output rrts_pkg::result_t            res_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  rrts_pkg::slot_e slot_state_q [SLOTS];
  rrts_pkg::slot_e slot_state_d [SLOTS];
  logic [PID_BITS-1:0] slot_pid_q [SLOTS];
  logic [PID_BITS-1:0] pid_ctr_q, pid_ctr_d;
  logic [SW-1:0]       run_slot_q, run_slot_d;
  logic                run_valid_q, run_valid_d;

  logic [31:0]         tpid_ext;
  logic [PID_BITS-1:0] tpid;
  logic [SW-1:0]       free_idx, match_idx;
  logic                free_found, match_found;

  logic                push, pop, pid_we, fifo_avail;
  logic [SW-1:0]       push_slot, head_slot;
  logic [CW-1:0]       fifo_cnt;
  rrts_pkg::status_e   status;
  logic [PID_BITS-1:0] cpid;
  logic                sw;

  logic [31:0]         cpid_ext, rpid_ext, rslot_ext, cnt_ext;

  assign tpid_ext = 32'(target_pid_i);
  assign tpid     = tpid_ext[PID_BITS-1:0];

  // lowest free slot and lowest live slot with matching pid
  always_comb begin
    free_idx    = '0;
    free_found  = 1'b0;
    match_idx   = '0;
    match_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_state_q[i] == rrts_pkg::SL_FREE) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
      if (slot_state_q[i] != rrts_pkg::SL_FREE && slot_pid_q[i] == tpid) begin
        match_idx   = SW'(i);
        match_found = 1'b1;
      end
    end
  end

  rrts_ready_fifo #(
    .SLOTS(SLOTS)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push && evt_en_i),
    .push_slot_i (push_slot),
    .pop_i       (pop && evt_en_i),
    .avail_o     (fifo_avail),
    .head_slot_o (head_slot),
    .count_o     (fifo_cnt)
  );

  always_comb begin
    slot_state_d = slot_state_q;
    pid_ctr_d    = pid_ctr_q;
    run_slot_d   = run_slot_q;
    run_valid_d  = run_valid_q;
    push         = 1'b0;
    push_slot    = '0;
    pop          = 1'b0;
    pid_we       = 1'b0;
    status       = rrts_pkg::STS_OK;
    cpid         = '0;
    sw           = 1'b0;
    unique case (rrts_pkg::func_e'(func_i))
      rrts_pkg::FN_CREATE: begin
        if (!free_found) begin
          status = rrts_pkg::STS_NO_SLOT;
        end else begin
          slot_state_d[free_idx] = rrts_pkg::SL_READY;
          pid_we    = 1'b1;
          cpid      = pid_ctr_q;
          pid_ctr_d = pid_ctr_q + 1'b1;
          push      = 1'b1;
          push_slot = free_idx;
        end
      end
      rrts_pkg::FN_TICK: begin
        if (run_valid_q) begin
          slot_state_d[run_slot_q] = rrts_pkg::SL_READY;
          push      = 1'b1;
          push_slot = run_slot_q;
        end
        pop = 1'b1;
        if (!fifo_avail) begin
          run_valid_d = 1'b0;
          run_slot_d  = '0;
          status      = rrts_pkg::STS_IDLE;
        end else begin
          run_valid_d = 1'b1;
          run_slot_d  = head_slot;
          slot_state_d[head_slot] = rrts_pkg::SL_RUN;
          sw = !run_valid_q || (head_slot != run_slot_q);
        end
      end
      rrts_pkg::FN_EXIT, rrts_pkg::FN_BLOCK: begin
        if (!run_valid_q) begin
          status = rrts_pkg::STS_IDLE;
        end else begin
          slot_state_d[run_slot_q] = (rrts_pkg::func_e'(func_i) == rrts_pkg::FN_EXIT) ?
                                     rrts_pkg::SL_FREE : rrts_pkg::SL_BLOCKED;
          sw  = 1'b1;
          pop = 1'b1;
          if (!fifo_avail) begin
            run_valid_d = 1'b0;
            run_slot_d  = '0;
            status      = rrts_pkg::STS_IDLE;
          end else begin
            run_valid_d = 1'b1;
            run_slot_d  = head_slot;
            slot_state_d[head_slot] = rrts_pkg::SL_RUN;
          end
        end
      end
      rrts_pkg::FN_UNBLOCK: begin
        if (!match_found || slot_state_q[match_idx] != rrts_pkg::SL_BLOCKED) begin
          status = rrts_pkg::STS_NO_MATCH;
        end else begin
          slot_state_d[match_idx] = rrts_pkg::SL_READY;
          push      = 1'b1;
          push_slot = match_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state_q[i] <= rrts_pkg::SL_FREE;
      end
      pid_ctr_q   <= PID_BITS'(1);
      run_slot_q  <= '0;
      run_valid_q <= 1'b0;
    end else if (evt_en_i) begin
      slot_state_q <= slot_state_d;
      pid_ctr_q    <= pid_ctr_d;
      run_slot_q   <= run_slot_d;
      run_valid_q  <= run_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_en_i && pid_we) begin
      slot_pid_q[free_idx] <= pid_ctr_q;
    end
  end

  // post-event view; a create never lands on the running slot
  assign cpid_ext  = 32'(cpid);
  assign rpid_ext  = run_valid_d ? 32'(slot_pid_q[run_slot_d]) : '0;
  assign rslot_ext = run_valid_d ? 32'(run_slot_d) : '0;
  assign cnt_ext   = 32'(fifo_cnt);

  always_comb begin
    res_o.status        = status;
    res_o.created_pid   = cpid_ext[rrts_pkg::PID_OUT_W-1:0];
    res_o.switched      = sw;
    res_o.running_valid = run_valid_d;
    res_o.running_slot  = rslot_ext[rrts_pkg::SLOT_OUT_W-1:0];
    res_o.running_pid   = rpid_ext[rrts_pkg::PID_OUT_W-1:0];
    res_o.ready_count   = cnt_ext[rrts_pkg::COUNT_OUT_W-1:0];
  end

  a_run_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (slot_state_q[run_slot_q] == rrts_pkg::SL_RUN))
    else $error("running slot not in run state");

  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_valid_q |-> (run_slot_q == '0))
    else $error("idle scheduler with nonzero run slot");

  a_pid_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_en_i && pid_we) |=> (pid_ctr_q == PID_BITS'($past(pid_ctr_q) + 1'b1)))
    else $error("pid counter did not advance on create");

endmodule
